FILE: rtl/ocr_pkg.sv
// shared types and constants of the online cluster rescaler
// no dependencies; used by ocr_alu, online_cluster_rescaler and the testbench
package ocr_pkg;

    localparam int ALU_W  = 72;  // dividend and product width of the shared unit
    localparam int ALU_BW = 40;  // multiplier and divisor width
    localparam int CNT_W  = 7;

    localparam logic [CNT_W-1:0] MUL_STEPS  = 7'd40;
    localparam logic [CNT_W-1:0] DIV_STEPS  = 7'd72;
    localparam logic [CNT_W-1:0] SQRT_STEPS = 7'd32;

    localparam logic [47:0] VAR_MAX = 48'hFFFF_FFFF_FFFF;
    localparam logic [30:0] OUT_MAX = 31'h7FFF_FFFF;

    // register indexes on the configuration port
    localparam logic [2:0] REG_CLUSTERS = 3'd0;
    localparam logic [2:0] REG_WINDOW   = 3'd1;
    localparam logic [2:0] REG_PEAK     = 3'd2;
    localparam logic [2:0] REG_START_A  = 3'd3;
    localparam logic [2:0] REG_START_B  = 3'd4;
    localparam logic [2:0] REG_START_C  = 3'd5;
    localparam logic [2:0] REG_START_D  = 3'd6;

    typedef enum logic [1:0] {
        CMD_UPDATE    = 2'd0,
        CMD_TRANSFORM = 2'd1,
        CMD_UPD_XFORM = 2'd2,
        CMD_REINIT    = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ALU_MUL  = 2'd0,
        ALU_DIV  = 2'd1,
        ALU_SQRT = 2'd2
    } t_alu_op;

    typedef struct packed {
        logic    start;
        t_alu_op op;
    } t_alu_req;

    typedef struct packed {
        logic [1:0]         cmd;
        logic signed [31:0] sample;
    } t_in_beat;

    typedef struct packed {
        logic [30:0] rescaled;
        logic [1:0]  chosen_cluster;
        logic        degenerate;
    } t_out_beat;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_INIT,
        ST_SCAN,
        ST_LOAD,
        ST_M_MUL,
        ST_M_SUM,
        ST_M_N2,
        ST_M_ADJ,
        ST_M_DIV,
        ST_M_WR,
        ST_H_ABS,
        ST_H_DIV,
        ST_V_MUL,
        ST_V_DIV,
        ST_P_MUL,
        ST_Q_MUL,
        ST_V_WR,
        ST_T_SCAN,
        ST_SQ_LO,
        ST_SQ_HI,
        ST_LIM,
        ST_PREP,
        ST_R_MUL,
        ST_R_DIV,
        ST_R_FIN,
        ST_DONE
    } t_state;

endpackage

FILE: rtl/ocr_alu.sv
// shared iterative unit: shift-add multiply, restoring divide, bit-pair square root
// depends on ocr_pkg
module ocr_alu (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ocr_pkg::t_alu_req             i_req,
    input  logic [ocr_pkg::ALU_W-1:0]     i_a,
    input  logic [ocr_pkg::ALU_BW-1:0]    i_b,
    output logic                          o_done,
    output logic [ocr_pkg::ALU_W-1:0]     o_res
);
    import ocr_pkg::*;

    logic             r_busy;
    logic             r_done;
    t_alu_op          r_op;
    logic [CNT_W-1:0] r_cnt;
    logic [ALU_W-1:0] r_acc;
    logic [ALU_W-1:0] r_opa;
    logic [ALU_W-1:0] r_opb;

    logic [ALU_W-1:0] div_rem;
    logic [ALU_W-1:0] sq_rem;
    logic [ALU_W-1:0] sq_trial;
    logic [ALU_W-1:0] add_a;
    logic [ALU_W-1:0] add_b;
    logic             add_sub;
    logic [ALU_W:0]   sum;
    logic             ge;

    assign div_rem  = {r_acc[ALU_W-2:0], r_opa[ALU_W-1]};
    assign sq_rem   = {r_acc[ALU_W-3:0], r_opa[63:62]};
    assign sq_trial = {r_opb[ALU_W-3:0], 2'b01};

    // the one adder, shared by every operation
    always_comb begin
        unique case (r_op)
            ALU_DIV: begin
                add_a   = div_rem;
                add_b   = r_opb;
                add_sub = 1'b1;
            end
            ALU_SQRT: begin
                add_a   = sq_rem;
                add_b   = sq_trial;
                add_sub = 1'b1;
            end
            default: begin
                add_a   = r_acc;
                add_b   = r_opa;
                add_sub = 1'b0;
            end
        endcase
    end

    assign sum = {1'b0, add_a} + {1'b0, (add_sub ? ~add_b : add_b)}
               + {{ALU_W{1'b0}}, add_sub};
    assign ge  = sum[ALU_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_op   <= ALU_MUL;
            r_cnt  <= '0;
        end else begin
            // done pulses for one cycle after the last step
            r_done <= !i_req.start && r_busy && (r_cnt == 7'd1);
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_op   <= i_req.op;
                r_acc  <= '0;
                r_opa  <= i_a;
                unique case (i_req.op)
                    ALU_DIV: begin
                        r_opb <= {{(ALU_W-ALU_BW){1'b0}}, i_b};
                        r_cnt <= DIV_STEPS;
                    end
                    ALU_SQRT: begin
                        r_opb <= '0;
                        r_cnt <= SQRT_STEPS;
                    end
                    default: begin
                        r_opb <= {{(ALU_W-ALU_BW){1'b0}}, i_b};
                        r_cnt <= MUL_STEPS;
                    end
                endcase
            end else if (r_busy) begin
                unique case (r_op)
                    ALU_DIV: begin
                        r_acc <= ge ? sum[ALU_W-1:0] : div_rem;
                        r_opa <= {r_opa[ALU_W-2:0], ge};
                    end
                    ALU_SQRT: begin
                        r_acc <= ge ? sum[ALU_W-1:0] : sq_rem;
                        r_opa <= {r_opa[ALU_W-3:0], 2'b00};
                        r_opb <= {r_opb[ALU_W-2:0], ge};
                    end
                    default: begin
                        if (r_opb[0]) begin
                            r_acc <= sum[ALU_W-1:0];
                        end
                        r_opa <= {r_opa[ALU_W-2:0], 1'b0};
                        r_opb <= {1'b0, r_opb[ALU_W-1:1]};
                    end
                endcase
                r_cnt <= r_cnt - 7'd1;
                if (r_cnt == 7'd1) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_comb begin
        unique case (r_op)
            ALU_DIV:  o_res = r_opa;
            ALU_SQRT: o_res = r_opb;
            default:  o_res = r_acc;
        endcase
    end

    assign o_done = r_done;

endmodule

FILE: rtl/online_cluster_rescaler.sv
// top level of the online cluster rescaler: sequencer, cluster state, result register
// depends on ocr_pkg and ocr_alu
//
// Each input beat carries a command and a signed Q16.16 sample. An update scans the
// active clusters one per cycle for the nearest mean, then refreshes that cluster's
// mean, variance and weight through one shared iterative unit, using four multiplies
// and three divides in that unit. A transform scans the means, takes two square roots
// and, unless the result is settled early, one multiply and one divide. Update-then-transform
// does both in turn. One beat is worked on at a time; the result sits in an output
// register, so the next beat is taken while it waits.
// Configuration writes land at once and are meant to be made while the block is idle.
module online_cluster_rescaler #(
    parameter int CLUSTERS = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  ocr_pkg::t_in_beat  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output ocr_pkg::t_out_beat o_out_data,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data
);
    import ocr_pkg::*;

    localparam int IW = (CLUSTERS > 1) ? $clog2(CLUSTERS) : 1;

    // configuration
    logic [2:0]         r_cfg_clusters;
    logic [15:0]        r_cfg_window;
    logic [30:0]        r_cfg_peak;
    logic signed [31:0] r_start [4];

    // cluster state, one read and write index
    logic signed [31:0] r_mean [CLUSTERS];
    logic [47:0]        r_var  [CLUSTERS];
    logic [15:0]        r_wt   [CLUSTERS];

    t_state             r_state, n_state;
    logic [IW-1:0]      r_idx;
    logic [IW-1:0]      r_best;
    logic [IW-1:0]      r_lo;
    logic [IW-1:0]      r_hi;
    logic [32:0]        r_bestd;
    logic signed [31:0] r_lo_m;
    logic signed [31:0] r_hi_m;
    logic [1:0]         r_cmd;
    logic signed [31:0] r_x;
    logic               r_upd;
    logic               r_issued;
    logic [15:0]        r_n;
    logic               r_neg;
    logic signed [51:0] r_s;
    logic [51:0]        r_num;
    logic signed [31:0] r_nm;
    logic [32:0]        r_a;
    logic [32:0]        r_h;
    logic [47:0]        r_t1;
    logic [ALU_W-1:0]   r_p;
    logic signed [35:0] r_llim;
    logic signed [35:0] r_ulim;
    logic signed [35:0] r_dx;
    logic [35:0]        r_span;
    logic [35:0]        r_ma;
    logic [35:0]        r_mb;
    logic [30:0]        r_lim;
    logic [30:0]        r_res;
    logic               r_deg;
    logic               r_ovalid;
    t_out_beat          r_odata;

    // shared unit
    t_alu_req           alu_req;
    logic [ALU_W-1:0]   alu_a;
    logic [ALU_BW-1:0]  alu_b;
    logic               alu_done;
    logic [ALU_W-1:0]   alu_res;

    ocr_alu u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (alu_req),
        .i_a     (alu_a),
        .i_b     (alu_b),
        .o_done  (alu_done),
        .o_res   (alu_res)
    );

    // active cluster count, clamped to 1..CLUSTERS
    logic [4:0]    k_act;
    logic [IW-1:0] k_last;
    always_comb begin
        k_act = {2'b00, r_cfg_clusters};
        if (k_act == 5'd0) begin
            k_act = 5'd1;
        end
        if (k_act > 5'(CLUSTERS)) begin
            k_act = 5'(CLUSTERS);
        end
    end
    assign k_last = IW'(k_act - 5'd1);

    logic signed [31:0] rd_mean;
    logic [47:0]        rd_var;
    logic [15:0]        rd_wt;
    assign rd_mean = r_mean[r_idx];
    assign rd_var  = r_var[r_idx];
    assign rd_wt   = r_wt[r_idx];

    logic               in_beat, out_beat, out_free, is_op;
    logic               scan_last, init_last;
    logic signed [32:0] scan_diff;
    logic [32:0]        scan_dist;
    logic               scan_take;
    logic [IW-1:0]      scan_best;
    logic signed [31:0] init_mean;
    logic [32:0]        mean_abs;
    logic [16:0]        n_p1;
    logic [50:0]        var_sum;
    logic signed [32:0] h_diff;
    logic               win_cap;

    assign in_beat   = i_in_valid && o_in_ready;
    assign out_beat  = r_ovalid && i_out_ready;
    assign out_free  = !r_ovalid || i_out_ready;
    assign scan_last = (r_idx == k_last);
    assign init_last = (r_idx == IW'(CLUSTERS - 1));

    // nearest mean, lowest index on ties
    assign scan_diff = {r_x[31], r_x} - {rd_mean[31], rd_mean};
    assign scan_dist = scan_diff[32] ? 33'(-scan_diff) : 33'(scan_diff);
    assign scan_take = (r_idx == '0) || (scan_dist < r_bestd);
    assign scan_best = scan_take ? r_idx : r_best;

    assign init_mean = (32'(r_idx) < 32'd4) ? r_start[2'(r_idx)] : 32'sd0;
    assign mean_abs  = rd_mean[31] ? 33'(-{1'b1, rd_mean}) : {1'b0, rd_mean};
    assign n_p1      = {1'b0, r_n} + 17'd1;
    assign var_sum   = {3'b000, r_t1} + {1'b0, r_p[65:16]};
    assign h_diff    = {r_x[31], r_x} - {r_nm[31], r_nm};
    assign win_cap   = (r_cfg_window != 16'd0) && (rd_wt >= r_cfg_window);

    assign is_op = (r_state == ST_M_MUL) || (r_state == ST_M_DIV) || (r_state == ST_H_DIV)
                || (r_state == ST_V_MUL) || (r_state == ST_V_DIV) || (r_state == ST_P_MUL)
                || (r_state == ST_Q_MUL) || (r_state == ST_SQ_LO) || (r_state == ST_SQ_HI)
                || (r_state == ST_R_MUL) || (r_state == ST_R_DIV);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_beat) begin
                    unique case (t_cmd'(i_in_data.cmd))
                        CMD_REINIT:    n_state = ST_INIT;
                        CMD_TRANSFORM: n_state = ST_T_SCAN;
                        default:       n_state = ST_SCAN;
                    endcase
                end
            end
            ST_INIT:   if (init_last) n_state = ST_DONE;
            ST_SCAN:   if (scan_last) n_state = ST_LOAD;
            ST_LOAD:   n_state = ST_M_MUL;
            ST_M_MUL:  if (alu_done) n_state = ST_M_SUM;
            ST_M_SUM:  n_state = ST_M_N2;
            ST_M_N2:   n_state = ST_M_ADJ;
            ST_M_ADJ:  n_state = ST_M_DIV;
            ST_M_DIV:  if (alu_done) n_state = ST_M_WR;
            ST_M_WR:   n_state = ST_H_ABS;
            ST_H_ABS:  n_state = ST_H_DIV;
            ST_H_DIV:  if (alu_done) n_state = ST_V_MUL;
            ST_V_MUL:  if (alu_done) n_state = ST_V_DIV;
            ST_V_DIV:  if (alu_done) n_state = ST_P_MUL;
            ST_P_MUL:  if (alu_done) n_state = ST_Q_MUL;
            ST_Q_MUL:  if (alu_done) n_state = ST_V_WR;
            ST_V_WR: begin
                n_state = (t_cmd'(r_cmd) == CMD_UPD_XFORM) ? ST_T_SCAN : ST_DONE;
            end
            ST_T_SCAN: if (scan_last) n_state = ST_SQ_LO;
            ST_SQ_LO:  if (alu_done) n_state = ST_SQ_HI;
            ST_SQ_HI:  if (alu_done) n_state = ST_LIM;
            ST_LIM:    n_state = (r_ulim <= r_llim) ? ST_DONE : ST_PREP;
            ST_PREP: begin
                if (r_cfg_peak != 31'd0) begin
                    n_state = (r_dx <= 36'sd0) ? ST_DONE : ST_R_MUL;
                end else if ((r_dx == 36'sd0) || (r_ulim == 36'sd0)
                          || (r_dx[35] != r_ulim[35])) begin
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_R_MUL;
                end
            end
            ST_R_MUL:  if (alu_done) n_state = ST_R_DIV;
            ST_R_DIV:  if (alu_done) n_state = ST_R_FIN;
            ST_R_FIN:  n_state = ST_DONE;
            ST_DONE:   if (out_free) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // outputs and shared unit requests
    always_comb begin
        o_in_ready    = (r_state == ST_IDLE);
        alu_req.start = is_op && !r_issued;
        alu_req.op    = ALU_MUL;
        alu_a         = '0;
        alu_b         = '0;
        unique case (r_state)
            ST_M_MUL: begin
                alu_a = ALU_W'(mean_abs);
                alu_b = ALU_BW'(r_n);
            end
            ST_M_DIV: begin
                alu_req.op = ALU_DIV;
                alu_a      = ALU_W'(r_num);
                alu_b      = ALU_BW'({n_p1, 1'b0});
            end
            ST_H_DIV: begin
                alu_req.op = ALU_DIV;
                alu_a      = ALU_W'(r_a);
                alu_b      = ALU_BW'(n_p1);
            end
            ST_V_MUL: begin
                alu_a = ALU_W'(rd_var);
                alu_b = ALU_BW'(r_n);
            end
            ST_V_DIV: begin
                alu_req.op = ALU_DIV;
                alu_a      = r_p;
                alu_b      = ALU_BW'(n_p1);
            end
            ST_P_MUL: begin
                alu_a = ALU_W'(r_h);
                alu_b = ALU_BW'(r_n);
            end
            ST_Q_MUL: begin
                alu_a = r_p;
                alu_b = ALU_BW'(r_h);
            end
            ST_SQ_LO, ST_SQ_HI: begin
                alu_req.op = ALU_SQRT;
                alu_a      = ALU_W'({rd_var, 16'h0000});
            end
            ST_R_MUL: begin
                alu_a = ALU_W'(r_ma);
                alu_b = ALU_BW'(r_mb);
            end
            ST_R_DIV: begin
                alu_req.op = ALU_DIV;
                alu_a      = r_p;
                alu_b      = ALU_BW'(r_span);
            end
            default: begin
                alu_req.op = ALU_MUL;
            end
        endcase
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_clusters <= 3'd4;
            r_cfg_window   <= '0;
            r_cfg_peak     <= '0;
            for (int i = 0; i < 4; i++) begin
                r_start[i] <= '0;
            end
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_CLUSTERS: r_cfg_clusters <= i_cfg_data[2:0];
                REG_WINDOW:   r_cfg_window   <= i_cfg_data[15:0];
                REG_PEAK:     r_cfg_peak     <= i_cfg_data[30:0];
                REG_START_A, REG_START_B, REG_START_C, REG_START_D: begin
                    r_start[2'(i_cfg_index - REG_START_A)] <= i_cfg_data;
                end
                default: ;
            endcase
        end
    end

    // sequencer and datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_idx    <= '0;
            r_best   <= '0;
            r_issued <= 1'b0;
            r_ovalid <= 1'b0;
            for (int i = 0; i < CLUSTERS; i++) begin
                r_mean[i] <= '0;
                r_var[i]  <= '0;
                r_wt[i]   <= '0;
            end
        end else begin
            r_state <= n_state;
            if (alu_req.start) begin
                r_issued <= 1'b1;
            end else if (alu_done) begin
                r_issued <= 1'b0;
                r_p      <= alu_res;
            end
            // result held until taken, refilled from the done state
            r_ovalid <= (r_ovalid && !out_beat) || ((r_state == ST_DONE) && out_free);

            unique case (r_state)
                ST_IDLE: begin
                    if (in_beat) begin
                        r_cmd  <= i_in_data.cmd;
                        r_x    <= i_in_data.sample;
                        r_upd  <= (t_cmd'(i_in_data.cmd) == CMD_UPDATE)
                               || (t_cmd'(i_in_data.cmd) == CMD_UPD_XFORM);
                        r_idx  <= '0;
                        r_best <= '0;
                        r_res  <= '0;
                        r_deg  <= 1'b0;
                    end
                end
                ST_INIT: begin
                    r_mean[r_idx] <= init_mean;
                    r_var[r_idx]  <= '0;
                    r_wt[r_idx]   <= (init_mean > 32'sd0) ? 16'd1 : 16'd0;
                    r_idx         <= r_idx + IW'(1);
                end
                ST_SCAN: begin
                    r_best <= scan_best;
                    if (scan_take) begin
                        r_bestd <= scan_dist;
                    end
                    r_idx <= scan_last ? scan_best : r_idx + IW'(1);
                end
                ST_LOAD: begin
                    // at or above the window size the weight stays and n is the window, else it counts up and saturates
                    if (win_cap) begin
                        r_n <= r_cfg_window;
                    end else begin
                        r_n <= rd_wt;
                        if (rd_wt != 16'hFFFF) begin
                            r_wt[r_idx] <= rd_wt + 16'd1;
                        end
                    end
                end
                ST_M_SUM: begin
                    r_s <= (rd_mean[31] ? -$signed({4'b0000, r_p[47:0]})
                                        : $signed({4'b0000, r_p[47:0]}))
                         + $signed({{20{r_x[31]}}, r_x});
                end
                ST_M_N2: begin
                    // numerator of the rounded mean: 2*num + (n+1)
                    r_s <= (r_s <<< 1) + $signed({35'd0, n_p1});
                end
                ST_M_ADJ: begin
                    // floor division of a negative value through its magnitude
                    r_neg <= r_s[51];
                    if (r_s[51]) begin
                        r_num <= 52'(-r_s) + {35'd0, r_n, 1'b1};
                    end else begin
                        r_num <= 52'(r_s);
                    end
                end
                ST_M_WR: begin
                    r_nm          <= r_neg ? (~r_p[31:0] + 32'd1) : r_p[31:0];
                    r_mean[r_idx] <= r_neg ? (~r_p[31:0] + 32'd1) : r_p[31:0];
                end
                ST_H_ABS: begin
                    r_a <= h_diff[32] ? 33'(-h_diff) : 33'(h_diff);
                end
                ST_H_DIV: begin
                    if (alu_done) begin
                        r_h <= alu_res[32:0];
                    end
                end
                ST_V_DIV: begin
                    if (alu_done) begin
                        r_t1 <= alu_res[47:0];
                    end
                end
                ST_V_WR: begin
                    r_var[r_idx] <= (var_sum > {3'b000, VAR_MAX}) ? VAR_MAX : var_sum[47:0];
                    r_idx        <= '0;
                end
                ST_T_SCAN: begin
                    if ((r_idx == '0) || (rd_mean < r_lo_m)) begin
                        r_lo   <= r_idx;
                        r_lo_m <= rd_mean;
                    end
                    if ((r_idx == '0) || (rd_mean > r_hi_m)) begin
                        r_hi   <= r_idx;
                        r_hi_m <= rd_mean;
                    end
                    if (scan_last) begin
                        if ((r_idx == '0) || (rd_mean < r_lo_m)) begin
                            r_idx <= r_idx;
                        end else begin
                            r_idx <= r_lo;
                        end
                    end else begin
                        r_idx <= r_idx + IW'(1);
                    end
                end
                ST_SQ_LO: begin
                    if (alu_done) begin
                        r_llim <= $signed({{4{r_lo_m[31]}}, r_lo_m})
                                - $signed({4'b0000, alu_res[31:0]});
                        r_idx  <= r_hi;
                    end
                end
                ST_SQ_HI: begin
                    if (alu_done) begin
                        r_ulim <= $signed({{4{r_hi_m[31]}}, r_hi_m})
                                + $signed({4'b0000, alu_res[31:0]});
                    end
                end
                ST_LIM: begin
                    r_deg  <= (r_ulim <= r_llim);
                    r_span <= 36'(r_ulim - r_llim);
                    r_dx   <= $signed({{4{r_x[31]}}, r_x}) - r_llim;
                end
                ST_PREP: begin
                    if (r_cfg_peak != 31'd0) begin
                        r_ma  <= 36'(r_dx);
                        r_mb  <= {5'd0, r_cfg_peak};
                        r_lim <= r_cfg_peak;
                    end else begin
                        r_ma  <= r_dx[35] ? 36'(-r_dx) : 36'(r_dx);
                        r_mb  <= r_ulim[35] ? 36'(-r_ulim) : 36'(r_ulim);
                        r_lim <= OUT_MAX;
                    end
                end
                ST_R_FIN: begin
                    // saturate at the peak or at full scale
                    if ((|r_p[ALU_W-1:31]) || (r_p[30:0] > r_lim)) begin
                        r_res <= r_lim;
                    end else begin
                        r_res <= r_p[30:0];
                    end
                end
                ST_DONE: begin
                    if (out_free) begin
                        r_odata.rescaled       <= r_res;
                        r_odata.chosen_cluster <= r_upd ? 2'(r_best) : 2'd0;
                        r_odata.degenerate     <= r_deg;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_odata;

endmodule

FILE: tb/online_cluster_rescaler_test.sv
// self-checking testbench of online_cluster_rescaler: directed and random beats,
// each result checked against a cycle-free predictor of the cluster statistics
// depends on ocr_pkg and the online_cluster_rescaler rtl
module online_cluster_rescaler_test;
    import ocr_pkg::*;

    localparam int CLUSTERS   = 4;
    localparam int CYCLE_CAP  = 6000000;
    localparam int IDLE_PCT   = 29;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    t_in_beat    in_data = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    t_out_beat   out_data;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;

    // predictor copy of the block state and registers
    longint      mean_st [CLUSTERS];
    logic [63:0] var_st  [CLUSTERS];
    int unsigned wgt_st  [CLUSTERS];
    int unsigned pr_clusters, pr_window, pr_peak;
    longint      pr_start [4];

    t_out_beat   pending_results[$];
    int          error_count = 0;
    int          cycle_count = 0;
    bit          gaps_on = 1'b1;   // random idling on both sides

    online_cluster_rescaler #(.CLUSTERS(CLUSTERS)) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // ---------------------------------------------------------------- predictor

    function automatic longint floor_div(longint num, longint d);
        if (num >= 0) return num / d;
        return -(((-num) + d - 1) / d);
    endfunction

    function automatic logic [63:0] int_sqrt(logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        r = '0;
        b = 64'h1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // floor(a*b/d) saturated at lim, on a full-width product
    function automatic logic [30:0] scale_sat(logic [127:0] a, logic [127:0] b,
                                              logic [127:0] d, logic [127:0] lim);
        logic [127:0] q;
        q = (a * b) / d;
        if (q > lim) return lim[30:0];
        return q[30:0];
    endfunction

    function automatic int unsigned active_clusters();
        if (pr_clusters < 1) return 1;
        if (pr_clusters > CLUSTERS) return CLUSTERS;
        return pr_clusters;
    endfunction

    function automatic logic [1:0] update_cluster(longint x);
        int unsigned k, best, w;
        longint      diff, bestd, gap, num, d, nm;
        logic [63:0] n, a, h, v, t;
        k = active_clusters();
        best = 0;
        bestd = 0;
        for (int i = 0; i < k; i++) begin
            diff = x - mean_st[i];
            gap = diff < 0 ? -diff : diff;
            if (i == 0 || gap < bestd) begin
                bestd = gap;
                best = i;
            end
        end
        w = wgt_st[best];
        if (pr_window != 0 && w >= pr_window) begin
            n = pr_window;
        end else begin
            n = w;
            if (w < 65535) wgt_st[best] = w + 1;
        end
        num = longint'(n) * mean_st[best] + x;
        d = longint'(n) + 1;
        nm = floor_div(2 * num + d, 2 * d);
        mean_st[best] = nm;
        diff = x - nm;
        a = diff < 0 ? -diff : diff;
        h = a / (n + 1);
        v = var_st[best] * n / (n + 1);
        t = n * h;                 // wraps at 64 bits
        t = t * h;
        v = v + (t >> 16);
        if (v > {16'h0, VAR_MAX}) v = {16'h0, VAR_MAX};
        var_st[best] = v;
        return best[1:0];
    endfunction

    function automatic logic [30:0] rescale_sample(longint x, output logic degen);
        int unsigned k, lo, hi;
        longint      llim, ulim, dx, span;
        k = active_clusters();
        lo = 0;
        hi = 0;
        for (int i = 1; i < k; i++) begin
            if (mean_st[i] < mean_st[lo]) lo = i;
            if (mean_st[i] > mean_st[hi]) hi = i;
        end
        llim = mean_st[lo] - longint'(int_sqrt(var_st[lo] << 16));
        ulim = mean_st[hi] + longint'(int_sqrt(var_st[hi] << 16));
        degen = 1'b0;
        if (ulim <= llim) begin
            degen = 1'b1;
            return '0;
        end
        span = ulim - llim;
        dx = x - llim;
        if (pr_peak != 0) begin
            if (dx <= 0) return '0;
            return scale_sat(dx, pr_peak, span, pr_peak);
        end
        if (dx == 0 || ulim == 0 || ((dx < 0) != (ulim < 0))) return '0;
        return scale_sat(dx < 0 ? -dx : dx, ulim < 0 ? -ulim : ulim, span, OUT_MAX);
    endfunction

    function automatic t_out_beat predict_beat(t_in_beat b);
        t_out_beat r;
        longint    x;
        logic      dg;
        r = '0;
        x = longint'(b.sample);
        if (b.cmd == CMD_REINIT) begin
            for (int i = 0; i < CLUSTERS; i++) begin
                mean_st[i] = (i < 4) ? pr_start[i] : 0;
                var_st[i] = '0;
                wgt_st[i] = (mean_st[i] > 0) ? 1 : 0;
            end
        end else begin
            if (b.cmd == CMD_UPDATE || b.cmd == CMD_UPD_XFORM)
                r.chosen_cluster = update_cluster(x);
            if (b.cmd == CMD_TRANSFORM || b.cmd == CMD_UPD_XFORM) begin
                r.rescaled = rescale_sample(x, dg);
                r.degenerate = dg;
            end
        end
        return r;
    endfunction

    // ---------------------------------------------------------------- driving

    task automatic send_beat(t_cmd cmd, logic [31:0] sample);
        t_in_beat b;
        b.cmd = cmd;
        b.sample = sample;
        @(negedge i_clk);
        while (gaps_on && $urandom_range(99) < IDLE_PCT) begin
            in_valid <= 1'b0;
            @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_data <= b;
        do @(posedge i_clk); while (!in_ready);
        pending_results.push_back(predict_beat(b));
    endtask

    // wait for the block to go idle: input lowered, every result back
    task automatic drain();
        @(negedge i_clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] value);
        @(negedge i_clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(negedge i_clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_CLUSTERS: pr_clusters = value[2:0];
            REG_WINDOW:   pr_window = value[15:0];
            REG_PEAK:     pr_peak = value[30:0];
            REG_START_A, REG_START_B, REG_START_C, REG_START_D: begin
                pr_start[idx - REG_START_A] = longint'(signed'(value));
            end
            default: ;
        endcase
    endtask

    // ---------------------------------------------------------------- checking

    task automatic report_mismatch(string field, longint got, longint want);
        $display("mismatch %s: got %0d, expected %0d at cycle %0d",
                 field, got, want, cycle_count);
        error_count++;
    endtask

    always @(posedge i_clk) begin
        t_out_beat want;
        if (i_rst_n && out_valid && out_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected beat", 1, 0);
            end else begin
                want = pending_results.pop_front();
                if (out_data.rescaled !== want.rescaled)
                    report_mismatch("rescaled", out_data.rescaled, want.rescaled);
                if (out_data.chosen_cluster !== want.chosen_cluster)
                    report_mismatch("chosen_cluster", out_data.chosen_cluster,
                                    want.chosen_cluster);
                if (out_data.degenerate !== want.degenerate)
                    report_mismatch("degenerate", out_data.degenerate, want.degenerate);
            end
        end
    end

    // receiver stalls
    always @(negedge i_clk) begin
        out_ready <= !gaps_on || ($urandom_range(99) >= IDLE_PCT);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_CAP) begin
            $display("online_cluster_rescaler_test: done, errors");
            $finish;
        end
    end

    // ---------------------------------------------------------------- tests

    // zeroed clusters give a degenerate range, then the sample extremes
    task automatic test_reset_state();
        send_beat(CMD_TRANSFORM, 32'h0);
        send_beat(CMD_UPDATE, 32'h7FFF_FFFF);
        send_beat(CMD_UPDATE, 32'h8000_0000);
        send_beat(CMD_UPD_XFORM, 32'h0);
        send_beat(CMD_TRANSFORM, 32'h7FFF_FFFF);
        send_beat(CMD_TRANSFORM, 32'h8000_0000);
        send_beat(CMD_UPD_XFORM, 32'hFFFF_FFFF);
    endtask

    // start means at the extremes, cluster count above the maximum, unknown index
    task automatic test_reinit();
        drain();
        write_reg(REG_START_A, 32'hFFFD_0000);
        write_reg(REG_START_B, 32'h0001_0000);
        write_reg(REG_START_C, 32'h7FFF_FFFF);
        write_reg(REG_START_D, 32'h8000_0000);
        write_reg(REG_CLUSTERS, 32'h7);
        write_reg(3'd7, 32'hDEAD_BEEF);
        send_beat(CMD_REINIT, 32'h1234_5678);
        send_beat(CMD_UPD_XFORM, 32'h0000_8000);
        send_beat(CMD_UPD_XFORM, 32'h7FFF_0000);
        send_beat(CMD_UPDATE, 32'h8000_0001);
        send_beat(CMD_TRANSFORM, 32'h0002_0000);
    endtask

    // peak scaling at both ends, windowed weight, zero cluster count
    task automatic test_peak_window();
        drain();
        write_reg(REG_PEAK, 32'hFFFF_FFFF);
        write_reg(REG_WINDOW, 32'h1);
        send_beat(CMD_UPD_XFORM, 32'h0001_8000);
        send_beat(CMD_UPD_XFORM, 32'hFFFF_0000);
        send_beat(CMD_TRANSFORM, 32'h8000_0000);
        drain();
        write_reg(REG_PEAK, 32'h1);
        write_reg(REG_CLUSTERS, 32'h0);
        write_reg(REG_WINDOW, 32'hFFFF);
        send_beat(CMD_UPD_XFORM, 32'h0004_0000);
        send_beat(CMD_UPD_XFORM, 32'h0000_0001);
        send_beat(CMD_REINIT, 32'h0);
        send_beat(CMD_TRANSFORM, 32'h7FFF_FFFF);
    endtask

    // one random phase: settings, reinitialise, then random commands on samples mostly around the start means
    task automatic test_random_phase(logic [2:0] k, logic [15:0] win, logic [31:0] peak,
                                     int spread_log, int beats, bit hold_off);
        longint spread, base, s;
        int     pick;
        t_cmd   cmd;
        drain();
        spread = longint'(1) << spread_log;
        write_reg(REG_CLUSTERS, 32'(k));
        write_reg(REG_WINDOW, 32'(win));
        write_reg(REG_PEAK, peak);
        for (int i = 0; i < 4; i++)
            write_reg(3'(REG_START_A + i),
                      32'(longint'($urandom_range(32'(2 * spread_log < 62 ? 2 * spread : 1)))
                          - spread));
        send_beat(CMD_REINIT, $urandom);
        for (int j = 0; j < beats; j++) begin
            if (hold_off && j == beats / 2) drain();
            pick = $urandom_range(99);
            if (pick < 45)      cmd = CMD_UPDATE;
            else if (pick < 75) cmd = CMD_UPD_XFORM;
            else if (pick < 97) cmd = CMD_TRANSFORM;
            else                cmd = CMD_REINIT;
            pick = $urandom_range(99);
            base = pr_start[$urandom_range(3)];
            if (pick < 70)
                s = base + longint'($urandom_range(32'(spread / 2))) - spread / 4;
            else if (pick < 90)
                s = longint'($urandom_range(32'(4 * spread))) - 2 * spread;
            else
                s = $urandom;
            send_beat(cmd, 32'(s));
        end
    endtask

    initial begin
        pr_clusters = 4;
        pr_window = 0;
        pr_peak = 0;
        for (int i = 0; i < CLUSTERS; i++) begin
            mean_st[i] = 0;
            var_st[i] = '0;
            wgt_st[i] = 0;
        end
        for (int i = 0; i < 4; i++) pr_start[i] = 0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_state();
        test_reinit();
        test_peak_window();
        test_random_phase(3'd4, 16'd0,     32'h0,         20, 150, 1'b0);
        test_random_phase(3'd1, 16'd0,     32'h0,         16, 140, 1'b0);
        test_random_phase(3'd2, 16'd1,     32'h7FFF_FFFF, 24, 150, 1'b1);
        gaps_on = 1'b0;
        test_random_phase(3'd3, 16'd65535, 32'h0001_0000, 18, 150, 1'b0);
        gaps_on = 1'b1;
        test_random_phase(3'd4, 16'd8,     32'h0,         28, 150, 1'b0);
        test_random_phase(3'd0, 16'd3,     32'h1,         22, 140, 1'b0);
        test_random_phase(3'd7, 16'd0,     32'h3FFF_FFFF, 30, 150, 1'b0);
        test_random_phase(3'd4, 16'd2,     32'h0,         17, 150, 1'b0);

        drain();
        repeat (50) @(posedge i_clk);
        if (error_count == 0) begin
            $display("online_cluster_rescaler_test: done, clean");
        end else begin
            $display("online_cluster_rescaler_test: done, errors");
        end
        $finish;
    end

endmodule
